// File: rtl/gsa_pkg.sv
// Package: shared constants, codes and transaction types of the slot allocator.
package gsa_pkg;

   // Table geometry
   localparam int CAPACITY  = 1024;
   localparam int GEN_WIDTH = 16;
   localparam int TAG_WIDTH = 32;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   // Operation codes
   localparam logic [1:0] OP_CREATE  = 2'd0;
   localparam logic [1:0] OP_DESTROY = 2'd1;
   localparam logic [1:0] OP_LOOKUP  = 2'd2;
   localparam logic [1:0] OP_READ    = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [IDX_W-1:0]     slot_index;
      logic [GEN_WIDTH-1:0] slot_generation;
      logic [TAG_WIDTH-1:0] entity_tag;
   } gsa_req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [IDX_W-1:0]     out_index;
      logic [GEN_WIDTH-1:0] out_generation;
      logic [TAG_WIDTH-1:0] out_entity;
      logic [CNT_W-1:0]     live_count;
   } gsa_rsp_type;

endpackage

// File: rtl/generational_slot_allocator_core.sv
// Top level: generational slot allocator with slot table, free stack and result register.
//
// Accepts one transaction per clock while the result side does not stall; each is held
// in stage one and then in the result register. Per-slot generation, live mark and
// entity tag sit in one memory read at the accept edge; the write of the transaction
// just ahead is forwarded from a bypass register. Freed slots go onto a LIFO stack
// kept in a memory together with their generation, with the top entry and the one
// below it held in registers so that back-to-back creates and destroys need no
// stall. A create with an empty stack takes the next never-used slot; when
// all slots are used and none is free it answers full. There is no clearing pass:
// the tables are only read at slots already handed out.
module generational_slot_allocator_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  gsa_pkg::gsa_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output gsa_pkg::gsa_rsp_type rsp_data
);
   import gsa_pkg::*;

   typedef struct packed {
      logic [GEN_WIDTH-1:0] gen;
      logic                 live;
      logic [TAG_WIDTH-1:0] tag;
   } slot_entry_type;

   typedef struct packed {
      logic [IDX_W-1:0]     idx;
      logic [GEN_WIDTH-1:0] gen;
   } stack_entry_type;

   slot_entry_type  slot_mem [CAPACITY];
   stack_entry_type stk_mem  [CAPACITY];

   logic            req_accept;
   logic            s1_move;
   logic            s1_valid_ff;
   gsa_req_type     s1_req_ff;
   slot_entry_type  slot_rd_ff;
   slot_entry_type  slot_cur;
   logic            byp_valid_ff;
   logic [IDX_W-1:0] byp_addr_ff;
   slot_entry_type  byp_data_ff;

   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] depth_ff, depth_in, depth_nx;
   stack_entry_type top_ff, top_in;
   stack_entry_type below_ff;
   logic [CNT_W-1:0] stk_ra_full;

   logic            slot_we;
   logic [IDX_W-1:0] slot_wa;
   slot_entry_type  slot_wd;
   logic            stk_we;
   logic [IDX_W-1:0] stk_wa;
   stack_entry_type stk_wd;

   logic            hit_ok;
   logic            idx_used;
   logic [IDX_W-1:0] new_idx;
   logic [GEN_WIDTH-1:0] new_gen;

   logic            rsp_valid_ff;
   gsa_rsp_type     rsp_data_ff, rsp_data_in;

   // Handshake: stage one advances when the result register is free or drains
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Forward the write of the previous transaction over the registered read
   assign slot_cur = (byp_valid_ff && byp_addr_ff == s1_req_ff.slot_index) ?
                     byp_data_ff : slot_rd_ff;

   assign idx_used = {1'b0, s1_req_ff.slot_index} < used_ff;
   assign hit_ok   = idx_used && slot_cur.live &&
                     (slot_cur.gen == s1_req_ff.slot_generation);

   // Execute the transaction held in stage one
   always_comb begin
      used_in     = used_ff;
      depth_in    = depth_ff;
      top_in      = top_ff;
      slot_we     = 1'b0;
      slot_wa     = s1_req_ff.slot_index;
      slot_wd     = slot_cur;
      stk_we      = 1'b0;
      stk_wa      = depth_ff[IDX_W-1:0];
      stk_wd      = '{idx: s1_req_ff.slot_index, gen: s1_req_ff.slot_generation};
      new_idx     = top_ff.idx;
      new_gen     = GEN_WIDTH'(top_ff.gen + 1'b1);
      rsp_data_in = '0;
      case (s1_req_ff.opcode)
         OP_CREATE: begin
            if (depth_ff != '0) begin
               new_idx  = top_ff.idx;
               new_gen  = GEN_WIDTH'(top_ff.gen + 1'b1);
               depth_in = CNT_W'(depth_ff - 1'b1);
               top_in   = below_ff;
            end else if (used_ff < CNT_W'(CAPACITY)) begin
               new_idx  = used_ff[IDX_W-1:0];
               new_gen  = GEN_WIDTH'(1);
               used_in  = CNT_W'(used_ff + 1'b1);
            end
            if (depth_ff != '0 || used_ff < CNT_W'(CAPACITY)) begin
               slot_we                    = 1'b1;
               slot_wa                    = new_idx;
               slot_wd                    = '{gen: new_gen, live: 1'b1,
                                              tag: s1_req_ff.entity_tag};
               rsp_data_in.status         = ST_OK;
               rsp_data_in.out_index      = new_idx;
               rsp_data_in.out_generation = new_gen;
            end else begin
               rsp_data_in.status = ST_FULL;
            end
         end
         OP_DESTROY: begin
            if (hit_ok) begin
               slot_we       = 1'b1;
               slot_wd.live  = 1'b0;
               stk_we        = 1'b1;
               top_in        = stk_wd;
               depth_in      = CNT_W'(depth_ff + 1'b1);
               rsp_data_in.status = ST_OK;
            end else begin
               rsp_data_in.status = ST_INVALID;
            end
         end
         OP_LOOKUP: begin
            if (hit_ok) begin
               rsp_data_in.status     = ST_OK;
               rsp_data_in.out_entity = slot_cur.tag;
            end else begin
               rsp_data_in.status = ST_INVALID;
            end
         end
         OP_READ: begin
            if (idx_used) begin
               rsp_data_in.status         = ST_OK;
               rsp_data_in.out_index      = s1_req_ff.slot_index;
               rsp_data_in.out_generation = slot_cur.gen;
            end else begin
               rsp_data_in.status = ST_INVALID;
            end
         end
         default: begin
            rsp_data_in.status = ST_INVALID;
         end
      endcase
      rsp_data_in.live_count = CNT_W'(used_in - depth_in);
   end

   // Keep the stack read one entry below the top that follows this edge
   assign depth_nx    = s1_move ? depth_in : depth_ff;
   assign stk_ra_full = CNT_W'(depth_nx - CNT_W'(2));

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         depth_ff     <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
            used_ff      <= used_in;
            depth_ff     <= depth_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_move && slot_we) begin
            byp_valid_ff <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
         top_ff      <= top_in;
      end
      if (s1_move && slot_we) begin
         byp_addr_ff <= slot_wa;
         byp_data_ff <= slot_wd;
      end
   end

   // Slot table: write from stage one, read at the accept edge
   always_ff @(posedge clock) begin
      if (s1_move && slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      if (req_accept) begin
         slot_rd_ff <= slot_mem[req_data.slot_index];
      end
   end

   // Free stack: push at the old depth, read the entry under the new top
   always_ff @(posedge clock) begin
      if (s1_move && stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      below_ff <= stk_mem[stk_ra_full[IDX_W-1:0]];
   end

endmodule

// File: rtl/gsa_checker.sv
// Checker: port-level assertions for the slot allocator, bound to the top level.
module gsa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input gsa_pkg::gsa_rsp_type rsp_data
);
   import gsa_pkg::*;

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed");

   // Report only defined status codes and a bounded live count
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= ST_FULL) &&
                    (rsp_data.live_count <= CNT_W'(CAPACITY)))
      else $error("result status or live count out of range");

   // Zero the handle and tag on a failed transaction
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.out_index == '0 && rsp_data.out_generation == '0 &&
         rsp_data.out_entity == '0)
      else $error("failed transaction carries a nonzero handle or tag");

   // Flag full only with every slot live
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |->
         rsp_data.live_count == CNT_W'(CAPACITY))
      else $error("full status with free slots left");

   // Present a result after an accepted transaction
   a_req_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("accepted transaction produced no result");

endmodule

bind generational_slot_allocator_core gsa_checker u_gsa_checker (.*);

// File: tb/sv/slot_map_check_pkg.sv
`timescale 1ns / 100ps
// Slot map scoreboard: predicts each allocator answer and checks the answers the block gives.
package slot_map_check_pkg;
   import gsa_pkg::*;

   class slot_map_scoreboard;
      logic [GEN_WIDTH-1:0] gen_table [CAPACITY];
      bit                   live_mark [CAPACITY];
      logic [TAG_WIDTH-1:0] tag_table [CAPACITY];
      int unsigned          free_stack [CAPACITY];
      int unsigned          free_depth = 0;
      int unsigned          slots_used = 0;
      gsa_rsp_type          awaited_results [$];
      int unsigned          mismatches = 0;

      // Accept a handle only inside the used range, with matching generation, while live.
      function bit handle_live(logic [IDX_W-1:0] idx, logic [GEN_WIDTH-1:0] gen);
         return idx < slots_used && gen_table[idx] == gen && live_mark[idx];
      endfunction

      function bit table_full();
         return free_depth == 0 && slots_used == CAPACITY;
      endfunction

      // Apply one accepted transaction to the table copy and queue its answer.
      function gsa_rsp_type record_request(gsa_req_type req);
         gsa_rsp_type rsp;
         int unsigned slot;
         rsp = '0;
         rsp.status = ST_OK;
         case (req.opcode)
            OP_CREATE: begin
               // pop the free stack first, else take the next never-used slot
               if (free_depth > 0) begin
                  free_depth--;
                  slot = free_stack[free_depth];
               end else if (slots_used < CAPACITY) begin
                  slot = slots_used;
                  slots_used++;
                  gen_table[slot] = '0;
               end else begin
                  slot = CAPACITY;
               end
               if (slot < CAPACITY) begin
                  gen_table[slot] = gen_table[slot] + 1'b1;
                  tag_table[slot] = req.entity_tag;
                  live_mark[slot] = 1'b1;
                  rsp.out_index = IDX_W'(slot);
                  rsp.out_generation = gen_table[slot];
               end else begin
                  rsp.status = ST_FULL;
               end
            end
            OP_DESTROY: begin
               if (handle_live(req.slot_index, req.slot_generation)) begin
                  live_mark[req.slot_index] = 1'b0;
                  free_stack[free_depth] = req.slot_index;
                  free_depth++;
               end else begin
                  rsp.status = ST_INVALID;
               end
            end
            OP_LOOKUP: begin
               if (handle_live(req.slot_index, req.slot_generation)) begin
                  rsp.out_entity = tag_table[req.slot_index];
               end else begin
                  rsp.status = ST_INVALID;
               end
            end
            default: begin
               // read by index reports the generation whether the slot is live or not
               if (req.slot_index < slots_used) begin
                  rsp.out_index = req.slot_index;
                  rsp.out_generation = gen_table[req.slot_index];
               end else begin
                  rsp.status = ST_INVALID;
               end
            end
         endcase
         rsp.live_count = CNT_W'(slots_used - free_depth);
         awaited_results = {awaited_results, rsp};
         return rsp;
      endfunction

      function void compare_field(string label, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, label, want, got);
         end
      endfunction

      // Compare one accepted result with the oldest awaited answer.
      function void check_result(gsa_rsp_type got);
         gsa_rsp_type want;
         if (awaited_results.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing awaited, expected none, actual %p",
                     $time, got);
            return;
         end
         want = awaited_results.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("out_index", want.out_index, got.out_index);
         compare_field("out_generation", want.out_generation, got.out_generation);
         compare_field("out_entity", want.out_entity, got.out_entity);
         compare_field("live_count", want.live_count, got.live_count);
      endfunction
   endclass

endpackage

// File: tb/sv/generational_slot_allocator_core_test.sv
`timescale 1ns / 100ps
// Testbench top: drives create, destroy, lookup and read traffic into the slot allocator.
module generational_slot_allocator_core_test;
   import gsa_pkg::*;
   import slot_map_check_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int IDLE_LIMIT   = 20000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 45;
   localparam int DRAIN_CYCLES = 10;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   gsa_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   gsa_rsp_type rsp_data;

   slot_map_scoreboard   slot_map;
   int unsigned          send_idle_pct  = 0;
   int unsigned          recv_stall_pct = 0;
   bit                   hold_request   = 1'b0;
   logic [IDX_W-1:0]     live_idx [$];
   logic [GEN_WIDTH-1:0] live_gen [$];

   always #4 clock = ~clock;

   generational_slot_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Offer one transaction, hold it until accepted, then predict and maybe idle.
   task automatic issue(input gsa_req_type item, input int pos, output gsa_rsp_type predicted);
      int k;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = slot_map.record_request(item);
      // keep the list of live handles in step with the table
      if (item.opcode == OP_CREATE && predicted.status == ST_OK) begin
         live_idx = {live_idx, predicted.out_index};
         live_gen = {live_gen, predicted.out_generation};
      end else if (item.opcode == OP_DESTROY && predicted.status == ST_OK) begin
         k = pos;
         if (k < 0 || live_idx[k] != item.slot_index) begin
            k = live_idx.size() - 1;
            while (live_idx[k] != item.slot_index) k--;
         end
         live_idx.delete(k);
         live_gen.delete(k);
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic apply(input logic [1:0] op, input int unsigned idx, input int unsigned gen,
                        input logic [TAG_WIDTH-1:0] tag, output gsa_rsp_type predicted);
      gsa_req_type item;
      item.opcode          = op;
      item.slot_index      = IDX_W'(idx);
      item.slot_generation = GEN_WIDTH'(gen);
      item.entity_tag      = tag;
      issue(item, -1, predicted);
   endtask

   // Build a mostly well-formed transaction from the live handles, with some noise.
   task automatic pick_random_item(output gsa_req_type item, output int pos);
      int unsigned pick;
      int unsigned k;
      pick = $urandom_range(99);
      pos = -1;
      item.opcode          = OP_CREATE;
      item.slot_index      = IDX_W'($urandom);
      item.slot_generation = GEN_WIDTH'($urandom);
      item.entity_tag      = TAG_WIDTH'($urandom);
      if (pick < 35) begin
         item.opcode = OP_CREATE;
      end else if (pick < 75 && live_idx.size() > 0) begin
         pos = $urandom_range(live_idx.size() - 1);
         item.opcode = (pick < 55) ? OP_DESTROY : OP_LOOKUP;
         item.slot_index = live_idx[pos];
         item.slot_generation = live_gen[pos];
      end else if (pick < 85 && slot_map.slots_used > 0) begin
         item.opcode = OP_READ;
         item.slot_index = IDX_W'($urandom_range(slot_map.slots_used - 1));
      end else begin
         // any opcode; half the time a live index with one generation bit flipped
         item.opcode = 2'($urandom);
         if (live_idx.size() > 0 && $urandom_range(1) == 1) begin
            k = $urandom_range(live_idx.size() - 1);
            item.slot_index = live_idx[k];
            item.slot_generation = live_gen[k] ^ (GEN_WIDTH'(1) << $urandom_range(GEN_WIDTH - 1));
         end
      end
   endtask

   task automatic run_random(input int unsigned count);
      gsa_req_type item;
      gsa_rsp_type predicted;
      int          pos;
      repeat (count) begin
         pick_random_item(item, pos);
         issue(item, pos, predicted);
      end
   endtask

   // Check results and drive the result-side stall, with an occasional long hold.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) slot_map.check_result(rsp_data);
         if (hold_request && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // End the run when neither side moves a transaction for too long.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("generational_slot_allocator_core verification failed");
      $finish;
   end

   initial begin
      gsa_rsp_type p;
      slot_map = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty table: every handle and index is out of range
      apply(OP_LOOKUP, 0, 0, 0, p);
      apply(OP_READ, 1023, 16'hFFFF, 32'hFFFF_FFFF, p);
      apply(OP_DESTROY, 0, 1, 0, p);
      // fresh slots come out at generation one; tag extremes
      apply(OP_CREATE, 1023, 16'hFFFF, 32'h0000_0000, p);
      apply(OP_CREATE, 0, 0, 32'hFFFF_FFFF, p);
      apply(OP_LOOKUP, 0, 1, 0, p);
      apply(OP_LOOKUP, 1, 1, 0, p);
      apply(OP_LOOKUP, 1, 2, 0, p);
      apply(OP_LOOKUP, 1, 16'hFFFF, 0, p);
      apply(OP_READ, 1, 0, 0, p);
      apply(OP_READ, 2, 0, 0, p);
      // destroy, then the same handle again and a lookup of the dead slot
      apply(OP_DESTROY, 0, 1, 0, p);
      apply(OP_DESTROY, 0, 1, 0, p);
      apply(OP_LOOKUP, 0, 1, 0, p);
      apply(OP_READ, 0, 0, 0, p);
      apply(OP_CREATE, 0, 0, 32'hA5A5_5A5A, p);
      // last freed slot comes back first
      apply(OP_DESTROY, 1, 1, 0, p);
      apply(OP_DESTROY, 0, 2, 0, p);
      apply(OP_CREATE, 0, 0, 32'h1234_5678, p);
      apply(OP_CREATE, 0, 0, 32'h8765_4321, p);
      apply(OP_CREATE, 0, 0, 32'h0F0F_F0F0, p);
      apply(OP_LOOKUP, 1023, 16'hFFFF, 32'hFFFF_FFFF, p);
      apply(OP_DESTROY, 1023, 16'hFFFF, 0, p);

      // no idling; hold off the result side so the block backs up
      hold_request = 1'b1;
      run_random(RANDOM_ITEMS);

      send_idle_pct  = 51;
      recv_stall_pct = 0;
      run_random(RANDOM_ITEMS);

      // fill every slot, then push creates against the full table
      send_idle_pct  = 0;
      recv_stall_pct = 51;
      while (!slot_map.table_full()) apply(OP_CREATE, $urandom, $urandom, $urandom, p);
      repeat (3) apply(OP_CREATE, $urandom, $urandom, $urandom, p);
      run_random(RANDOM_ITEMS);

      send_idle_pct  = 26;
      recv_stall_pct = 26;
      run_random(RANDOM_ITEMS);

      // drain outstanding results, then let the pipeline settle
      req_valid <= 1'b0;
      while (slot_map.awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (slot_map.mismatches == 0) begin
         $display("generational_slot_allocator_core verification clean");
      end else begin
         $display("generational_slot_allocator_core verification failed");
      end
      $finish;
   end

endmodule

// File: generational_slot_allocator_core.f
rtl/gsa_pkg.sv
rtl/generational_slot_allocator_core.sv
rtl/gsa_checker.sv
tb/sv/slot_map_check_pkg.sv
tb/sv/generational_slot_allocator_core_test.sv
